[sv/lspe_pkg.sv]
// Shared constants and types of the LED strip pulse encoder.
package lspe_pkg;

    localparam int MAX_LEDS = 1024;
    localparam int LED_AW   = $clog2(MAX_LEDS);
    localparam int LEN_W    = $clog2(MAX_LEDS + 1);

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int BYTE_W   = 8;
    localparam int PIX_W    = 3 * BYTE_W;
    localparam int STATUS_W = 2;
    localparam int WIDTH_W  = 12;
    localparam int RSLOT_W  = 8;
    localparam int BIT_W    = 5;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 12;

    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 16;

    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_TIMER  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

    localparam logic [CFG_AW-1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_TIMING_ONE  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_TIMING_ZERO = 2'd2;
    localparam logic [CFG_AW-1:0] REG_RESET_SLOTS = 2'd3;

    localparam logic [LEN_W-1:0]   RST_LED_COUNT   = 11'd1;
    localparam logic [WIDTH_W-1:0] RST_TIMING_ONE  = 12'd850;
    localparam logic [WIDTH_W-1:0] RST_TIMING_ZERO = 12'd400;
    localparam logic [RSLOT_W-1:0] RST_RESET_SLOTS = 8'd48;

    localparam logic [BIT_W-1:0] BIT_LAST = 5'd23;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                pulse_valid;
        logic [WIDTH_W-1:0]  pulse_width;
        logic                frame_end;
    } t_result;

endpackage

[sv/led_strip_pulse_encoder.sv]
// Top level of the LED strip pulse encoder: pixel store, fill walker and frame sequencer.
//
//  channel   direction  handshake                        payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata op,index,count,red,green,blue; tlast
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata status,pulse_valid,width; tlast
//  cfg       in         i_cfg_wen                        i_cfg_index, i_cfg_data
//
// Writes, requests, timer events and idle slot ticks are handled in the idle state itself.
// A slot tick during a frame also passes through the tick state, which uses the pixel store read.
// A fill paints its pixels one at a time in the fill state, the store having one write port.
// After reset the store is cleared one entry a cycle, with no transaction taken.
// A result waits in the output register; the next transaction is taken as it leaves.
module led_strip_pulse_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // op[2:0], index[12:3], count[23:13], red[31:24], green[39:32], blue[47:40]
    input  logic [lspe_pkg::IN_DW-1:0]   i_s_axis_tdata,
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // status[1:0], pulse_valid[2], pulse_width[14:3], zero[15]
    output logic [lspe_pkg::OUT_DW-1:0]  o_m_axis_tdata,
    output logic                         o_m_axis_tlast,
    input  logic                         i_cfg_wen,
    input  logic [lspe_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [lspe_pkg::CFG_DW-1:0]  i_cfg_data
);
    import lspe_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_TICK  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [LEN_W-1:0]   r_led_count;
    logic [WIDTH_W-1:0] r_timing_one, r_timing_zero;
    logic [RSLOT_W-1:0] r_reset_slots;

    logic [PIX_W-1:0]   r_mem [MAX_LEDS];
    logic [PIX_W-1:0]   r_rdata;

    logic [LED_AW-1:0]  r_clr, n_clr;
    logic [LED_AW-1:0]  r_fill_addr, n_fill_addr;
    logic [LED_AW-1:0]  r_fill_last, n_fill_last;
    logic [PIX_W-1:0]   r_colour, n_colour;
    logic               r_pending, n_pending;
    logic               r_sending, n_sending;
    logic               r_in_data, n_in_data;
    logic [RSLOT_W-1:0] r_rst_cnt, n_rst_cnt;
    logic [LED_AW-1:0]  r_led, n_led;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [LED_AW-1:0]  r_last_led, n_last_led;
    logic               r_ovalid, n_ovalid;
    t_result            r_res, n_res;

    logic               w_we;
    logic [LED_AW-1:0]  w_waddr;
    logic [PIX_W-1:0]   w_wdata;

    logic               w_s_acc, w_m_acc;
    logic [OP_W-1:0]    w_op;
    logic [INDEX_W-1:0] w_idx;
    logic [COUNT_W-1:0] w_cnt;
    logic [PIX_W-1:0]   w_in_colour;
    logic [LEN_W-1:0]   w_len;
    logic               w_idx_bad;
    logic [LEN_W:0]     w_fill_sum, w_fill_end;
    logic [PIX_W-1:0]   w_grb;
    logic [BIT_W-1:0]   w_bit_sel;

    assign w_op        = i_s_axis_tdata[2:0];
    assign w_idx       = i_s_axis_tdata[12:3];
    assign w_cnt       = i_s_axis_tdata[23:13];
    assign w_in_colour = {i_s_axis_tdata[31:24], i_s_axis_tdata[39:32],
                          i_s_axis_tdata[47:40]};

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_acc = r_ovalid && i_m_axis_tready;

    always_comb begin
        priority if (r_led_count == '0) begin
            w_len = LEN_W'(1);
        end else if (r_led_count > LEN_W'(MAX_LEDS)) begin
            w_len = LEN_W'(MAX_LEDS);
        end else begin
            w_len = r_led_count;
        end
    end

    assign w_idx_bad  = {1'b0, w_idx} >= w_len;
    assign w_fill_sum = {2'b00, w_idx} + {1'b0, w_cnt};
    assign w_fill_end = (w_fill_sum > {1'b0, w_len}) ? {1'b0, w_len} : w_fill_sum;

    assign w_grb     = {r_rdata[15:8], r_rdata[23:16], r_rdata[7:0]};
    assign w_bit_sel = BIT_LAST - r_bit;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_fill_addr = r_fill_addr;
        n_fill_last = r_fill_last;
        n_colour    = r_colour;
        n_pending   = r_pending;
        n_sending   = r_sending;
        n_in_data   = r_in_data;
        n_rst_cnt   = r_rst_cnt;
        n_led       = r_led;
        n_bit       = r_bit;
        n_last_led  = r_last_led;
        n_ovalid    = r_ovalid && !w_m_acc;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + LED_AW'(1);
                if (r_clr == LED_AW'(MAX_LEDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_s_acc) begin
                    n_res    = '0;
                    n_ovalid = 1'b1;
                    unique case (w_op)
                        OP_WRITE: begin
                            priority if (r_sending) begin
                                n_res.status = ST_BUSY;
                            end else if (w_idx_bad) begin
                                n_res.status = ST_INVALID;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_idx;
                                w_wdata = w_in_colour;
                                if (i_s_axis_tlast) begin
                                    n_sending  = 1'b1;
                                    n_rst_cnt  = r_reset_slots;
                                    n_in_data  = (r_reset_slots == '0);
                                    n_led      = '0;
                                    n_bit      = '0;
                                    n_last_led = LED_AW'(w_len - LEN_W'(1));
                                end
                            end
                        end
                        OP_FILL: begin
                            priority if (r_sending) begin
                                n_res.status = ST_BUSY;
                            end else if (w_cnt == '0 || w_idx_bad) begin
                                n_res.status = ST_INVALID;
                            end else begin
                                n_pending   = 1'b1;
                                n_fill_addr = w_idx;
                                n_fill_last = LED_AW'(w_fill_end - (LEN_W + 1)'(1));
                                n_colour    = w_in_colour;
                                n_state     = S_FILL;
                            end
                        end
                        OP_UPDATE: begin
                            n_pending = 1'b1;
                        end
                        OP_TIMER: begin
                            if (r_pending && !r_sending) begin
                                n_pending  = 1'b0;
                                n_sending  = 1'b1;
                                n_rst_cnt  = r_reset_slots;
                                n_in_data  = (r_reset_slots == '0);
                                n_led      = '0;
                                n_bit      = '0;
                                n_last_led = LED_AW'(w_len - LEN_W'(1));
                            end
                        end
                        OP_TICK: begin
                            if (r_sending) begin
                                n_ovalid = 1'b0;
                                n_state  = S_TICK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we        = 1'b1;
                w_waddr     = r_fill_addr;
                w_wdata     = r_colour;
                n_fill_addr = r_fill_addr + LED_AW'(1);
                if (r_fill_addr == r_fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                n_state           = S_IDLE;
                n_ovalid          = 1'b1;
                n_res             = '0;
                n_res.pulse_valid = 1'b1;
                if (!r_in_data) begin
                    n_rst_cnt = r_rst_cnt - RSLOT_W'(1);
                    if (r_rst_cnt == RSLOT_W'(1)) begin
                        n_in_data = 1'b1;
                    end
                end else begin
                    n_res.pulse_width = w_grb[w_bit_sel] ? r_timing_one : r_timing_zero;
                    if (r_bit == BIT_LAST) begin
                        n_bit = '0;
                        if (r_led == r_last_led) begin
                            n_res.frame_end = 1'b1;
                            n_sending       = 1'b0;
                        end else begin
                            n_led = r_led + LED_AW'(1);
                        end
                    end else begin
                        n_bit = r_bit + BIT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_led];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_pending     <= 1'b0;
            r_sending     <= 1'b0;
            r_in_data     <= 1'b0;
            r_ovalid      <= 1'b0;
            r_led_count   <= RST_LED_COUNT;
            r_timing_one  <= RST_TIMING_ONE;
            r_timing_zero <= RST_TIMING_ZERO;
            r_reset_slots <= RST_RESET_SLOTS;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pending <= n_pending;
            r_sending <= n_sending;
            r_in_data <= n_in_data;
            r_ovalid  <= n_ovalid;
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    REG_LED_COUNT:   r_led_count   <= i_cfg_data[LEN_W-1:0];
                    REG_TIMING_ONE:  r_timing_one  <= i_cfg_data[WIDTH_W-1:0];
                    REG_TIMING_ZERO: r_timing_zero <= i_cfg_data[WIDTH_W-1:0];
                    REG_RESET_SLOTS: r_reset_slots <= i_cfg_data[RSLOT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_addr <= n_fill_addr;
        r_fill_last <= n_fill_last;
        r_colour    <= n_colour;
        r_rst_cnt   <= n_rst_cnt;
        r_led       <= n_led;
        r_bit       <= n_bit;
        r_last_led  <= n_last_led;
        r_res       <= n_res;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_res.pulse_width, r_res.pulse_valid, r_res.status};
    assign o_m_axis_tlast  = r_res.frame_end;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("transaction taken during the store clearing pass");

    a_tick_only_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_sending && !r_ovalid))
        else $error("slot read without a frame or with a result still waiting");

    a_no_write_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !r_sending)
        else $error("pixel store written during a frame");

    a_frame_end_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TICK) && n_res.frame_end) |=> (!r_sending && o_m_axis_tdata[2]))
        else $error("frame end without the frame closing");
`endif

endmodule
